/* src/median_filter_3x3_stream_unit_defines.svh */
// Assertion macros for the 3x3 median filter stream unit.
// Expects signals clk and rst_n in the scope of use; no other dependencies.
`ifndef MEDIAN_FILTER_3X3_STREAM_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_3X3_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MF3_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mf3 assertion failed");

// Next-cycle implication, checked outside reset.
`define MF3_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mf3 assertion failed");

`endif

/* src/mf3_pkg.sv */
// Shared types and constants for the 3x3 median filter stream unit.
// No dependencies; imported by every module of the block.
package mf3_pkg;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int MIN_DIM   = 3;
  localparam int DIM_MAX   = 4095;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd1080;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic vld;
    logic border;
    logic last;
  } mf3_tag_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mf3_div_stat_t;

endpackage

/* src/mf3_median.sv */
// Three-stage 3x3 median network with border bypass and output register.
// Depends on mf3_pkg for pixel, window and tag types.
module mf3_median
  import mf3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  win_t     win,
  input  mf3_tag_t tag_in,
  output pix_t     pix_out,
  output mf3_tag_t tag_out
);

  function automatic pix_t min2(input pix_t a, input pix_t b);
    min2 = (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    max2 = (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    med3 = max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  logic [2:0][PIX_W-1:0] mn2_r, md2_r, mx2_r;
  pix_t                  ctr2_r, ctr3_r;
  mf3_tag_t              tag2_r, tag3_r, tag4_r;
  pix_t                  lo3_r, mi3_r, hi3_r;
  pix_t                  pix4_r;

  // Stage 2: sort each window column.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mn2_r[k] <= min2(min2(win[3*k], win[3*k+1]), win[3*k+2]);
        md2_r[k] <= med3(win[3*k], win[3*k+1], win[3*k+2]);
        mx2_r[k] <= max2(max2(win[3*k], win[3*k+1]), win[3*k+2]);
      end
      ctr2_r <= win[4];
    end
  end

  // Stage 3: max of mins, median of mids, min of maxes.
  always_ff @(posedge clk) begin
    if (en) begin
      lo3_r  <= max2(max2(mn2_r[0], mn2_r[1]), mn2_r[2]);
      mi3_r  <= med3(md2_r[0], md2_r[1], md2_r[2]);
      hi3_r  <= min2(min2(mx2_r[0], mx2_r[1]), mx2_r[2]);
      ctr3_r <= ctr2_r;
    end
  end

  // Stage 4: final median or centre pass-through at the border.
  always_ff @(posedge clk) begin
    if (en) begin
      pix4_r <= tag3_r.border ? ctr3_r : med3(lo3_r, mi3_r, hi3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else if (en) begin
      tag2_r <= tag_in;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  assign pix_out = pix4_r;
  assign tag_out = tag4_r;

endmodule

/* src/mf3_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on mf3_pkg for the status struct.
module mf3_div
  import mf3_pkg::*;
#(
  parameter int DIVIDEND_W = 23,
  parameter int DIVISOR_W  = 12
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder,
  output mf3_div_stat_t         stat
);

  localparam int CNT_BITS = $clog2(DIVIDEND_W + 1);

  logic [CNT_BITS-1:0]   cnt_r;
  logic                  done_r;
  logic [DIVIDEND_W-1:0] dq_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  take;

  always_comb begin
    trial = {rem_r, dq_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, divisor};
    take  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_BITS'(DIVIDEND_W);
      done_r <= 1'b0;
    end else begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
      done_r <= (cnt_r == CNT_BITS'(1));
    end
  end

  // Shift quotient bits in from the bottom as the dividend moves out the top.
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dq_r  <= {dq_r[DIVIDEND_W-2:0], take};
      rem_r <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient  = dq_r;
  assign remainder = rem_r;
  assign stat.busy = (cnt_r != '0) || done_r;
  assign stat.done = done_r;

endmodule

/* src/median_filter_3x3_stream_unit.sv */
// 3x3 median filter over a raster-order stream of 8-bit gray pixels.
// Uses mf3_pkg, mf3_median, mf3_div and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready, in_op, in_pixel_in) takes one item per
//   cycle while in_ready is high. in_op push feeds a pixel; once the frame is
//   complete, W+1 drain items flush the remaining results. Pushes past frame
//   end and drains before it are taken and dropped.
//   Output channel (out_valid/out_ready, out_pixel_out, out_frame_last)
//   gives one result per effective item from input W+1 onward; the last
//   result of the frame carries out_frame_last and restarts all counters.
//   Throughput: one item per cycle while in_ready is high, set by the
//   line-store read port, which is read once and written once per item.
//   Pipeline: the item that completes a result passes through line-store read,
//   window shift, column sort, merge and final median registers, in order.
//   Receiver stall: the whole pipe holds and in_ready drops while out_valid
//   is high and out_ready is low.
//   Configuration (cfg_wr_en, cfg_index, cfg_data) is taken without a handshake.
//   Each write blocks input while it is pending and while the bit-serial
//   divider rebuilds the output row and column from the output count.
//   Reset: synchronous, active low; sizes return to 1920 x 1080, counters
//   and window clear. Line stores are not cleared.
`include "median_filter_3x3_stream_unit_defines.svh"

module median_filter_3x3_stream_unit
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_frame_last,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int OCNT_W = $clog2(MAX_WIDTH * DIM_MAX + 1);
  localparam int CW     = ((WW > DIM_W) ? WW : DIM_W) + 1;
  localparam int PW     = WW + DIM_W;

  // Configuration
  logic [DIM_W-1:0] frame_width_r, frame_height_r;
  logic [WW-1:0]    w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [PW-1:0]    prod;
  logic [OCNT_W-1:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_r < DIM_W'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (CW'(frame_width_r) > CW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    h_eff = (frame_height_r < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) : frame_height_r;
    prod  = PW'(w_eff) * PW'(h_eff);
  end

  always_ff @(posedge clk) begin
    total_r <= prod[OCNT_W-1:0];
  end

  // Counters
  logic [AW-1:0]     col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [OCNT_W-1:0] oc_r, oc_nxt;
  logic [AW-1:0]     ocol_r, ocol_nxt;
  logic [DIM_W-1:0]  orow_r, orow_nxt;

  logic          en, acc, is_drain, row_ge_h, push_rdy, adv, emit;
  logic          border, last;
  logic [WW-1:0] col_inc, ocol_inc;
  logic          col_wrap, ocol_wrap;
  logic [DIM_W-1:0] row_inc, orow_inc;

  logic                 div_pend_r;
  mf3_div_stat_t        div_st;
  logic [OCNT_W-1:0]    div_quo;
  logic [WW-1:0]        div_rem;

  mf3_tag_t out_tag;

  assign en       = !out_valid || out_ready;
  assign in_ready = en && !div_pend_r && !div_st.busy && !cfg_wr_en;
  assign acc      = in_valid && in_ready;
  assign is_drain = (in_op == OP_DRAIN);
  assign row_ge_h = (row_r >= h_eff);
  assign push_rdy = (row_r >= DIM_W'(2)) || ((row_r == DIM_W'(1)) && (col_r != '0));
  assign adv      = acc && (is_drain ? row_ge_h : !row_ge_h);
  assign emit     = adv && (is_drain || push_rdy);

  always_comb begin
    col_inc   = WW'(col_r) + 1'b1;
    col_wrap  = (col_inc >= w_eff);
    row_inc   = (row_r == DIM_W'(DIM_MAX)) ? row_r : row_r + 1'b1;
    ocol_inc  = WW'(ocol_r) + 1'b1;
    ocol_wrap = (ocol_inc >= w_eff);
    orow_inc  = (orow_r == DIM_W'(DIM_MAX)) ? orow_r : orow_r + 1'b1;
    border    = (orow_r == '0) || ((CW'(orow_r) + 1'b1) >= CW'(h_eff)) ||
                (ocol_r == '0) || ocol_wrap;
    last      = ((OCNT_W+1)'(oc_r) + 1'b1) >= (OCNT_W+1)'(total_r);
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    oc_nxt   = oc_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (adv) begin
      col_nxt = col_wrap ? '0 : col_inc[AW-1:0];
      if (col_wrap) begin
        row_nxt = row_inc;
      end
    end
    if (emit) begin
      if (last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        oc_nxt   = '0;
        ocol_nxt = '0;
        orow_nxt = '0;
      end else begin
        oc_nxt   = oc_r + 1'b1;
        ocol_nxt = ocol_wrap ? '0 : ocol_inc[AW-1:0];
        if (ocol_wrap) begin
          orow_nxt = orow_inc;
        end
      end
    end
    // Reload the output position after a size change.
    if (div_st.done) begin
      ocol_nxt = div_rem[AW-1:0];
      orow_nxt = (div_quo > OCNT_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : div_quo[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      oc_r       <= '0;
      ocol_r     <= '0;
      orow_r     <= '0;
      div_pend_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      oc_r       <= oc_nxt;
      ocol_r     <= ocol_nxt;
      orow_r     <= orow_nxt;
      div_pend_r <= cfg_wr_en;
    end
  end

  mf3_div #(
    .DIVIDEND_W (OCNT_W),
    .DIVISOR_W  (WW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_pend_r),
    .dividend  (oc_r),
    .divisor   (w_eff),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_st)
  );

  // Line stores and read stage
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  pix_t             up_rd_r, lo_rd_r;
  logic             s1_vld_r;
  logic [AW-1:0]    s1_addr_r;
  pix_t             s1_px_r;
  mf3_tag_t         s1_tag_r;
  logic             wr_en;

  assign wr_en = en && s1_vld_r;

  // Read at the item's column; write back from the read stage registers once the pipe moves, upper takes old lower.
  always_ff @(posedge clk) begin
    if (adv) begin
      up_rd_r <= upper_mem[col_r];
      lo_rd_r <= lower_mem[col_r];
    end
    if (wr_en) begin
      upper_mem[s1_addr_r] <= lo_rd_r;
      lower_mem[s1_addr_r] <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r <= col_r;
      s1_px_r   <= is_drain ? '0 : in_pixel_in;
      s1_tag_r  <= '{vld: emit, border: border, last: last};
    end
  end

  // Window: shift in the new column (upper, lower, current).
  win_t     win_r;
  mf3_tag_t win_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      win_tag_r <= '0;
    end else begin
      if (wr_en) begin
        win_r[5:0] <= win_r[8:3];
        win_r[6]   <= up_rd_r;
        win_r[7]   <= lo_rd_r;
        win_r[8]   <= s1_px_r;
      end
      if (en) begin
        win_tag_r <= s1_vld_r ? s1_tag_r : '0;
      end
    end
  end

  mf3_median u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .win     (win_r),
    .tag_in  (win_tag_r),
    .pix_out (out_pixel_out),
    .tag_out (out_tag)
  );

  assign out_valid      = out_tag.vld;
  assign out_frame_last = out_tag.last;

  // Checks
  `MF3_ASSERT_IMPL(a_ram_no_overlap, wr_en && adv, s1_addr_r != col_r)
  `MF3_ASSERT_IMPL(a_no_accept_in_div, div_pend_r || div_st.busy, !in_ready)
  `MF3_ASSERT_IMPL(a_out_col_in_range, !div_pend_r && !div_st.busy, WW'(ocol_r) < w_eff)
  `MF3_ASSERT_NEXT(a_cfg_blocks_input, cfg_wr_en, !in_ready)

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for median_filter_3x3_stream_unit: directed table of pixel and drain items,
// then random frames, each filtered pixel checked against table values or an in-line predictor.
// Depends on mf3_pkg and the unit itself.
module tb;
  import mf3_pkg::*;

  localparam int MAX_W        = 2048;
  localparam int SETTLE_CYC   = 16;
  localparam int QUIET_LIMIT  = 5000;
  localparam int SQUEEZE_CYC  = 400;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PRINT_CAP    = 40;

  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_NONE,
    ROW_VALUE
  } row_kind_e;

  typedef struct packed {
    logic             cfg_en;
    cfg_reg_t         cfg_reg;
    logic [DIM_W-1:0] cfg_val;
    op_t              op;
    pix_t             px;
    row_kind_e        kind;
    pix_t             exp_px;
    logic             exp_last;
  } dir_row_t;

  typedef struct packed {
    pix_t px;
    logic last;
  } filt_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_op = 1'b0;
  logic [PIX_W-1:0]     in_pixel_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_frame_last;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  bit calm = 1'b0;
  bit squeeze_req = 1'b0;
  int mismatch_count = 0;

  // predictor state
  pix_t             upper_line [MAX_W];
  pix_t             lower_line [MAX_W];
  pix_t             win [9];
  int unsigned      col_in = 0;
  int unsigned      row_in = 0;
  int unsigned      out_cnt = 0;
  logic [DIM_W-1:0] width_reg = WIDTH_RST;
  logic [DIM_W-1:0] height_reg = HEIGHT_RST;
  bit               frame_closed = 1'b0;
  filt_res_t        expected_pixels [$];

  // Sizes are 3x3 at the start of the table; a 3x4 frame follows whose height
  // drops to 3 after five pixels.
  dir_row_t dir_rows [29] = '{
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_DRAIN, 8'd0,   ROW_NONE,  8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd255, ROW_NONE,  8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd0,   ROW_NONE,  8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd17,  ROW_NONE,  8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd200, ROW_NONE,  8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd1,   ROW_VALUE, 8'd255, 1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd100, ROW_VALUE, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd254, ROW_VALUE, 8'd17,  1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd128, ROW_VALUE, 8'd200, 1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd64,  ROW_VALUE, 8'd100, 1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd77,  ROW_NONE,  8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_DRAIN, 8'd0,   ROW_VALUE, 8'd100, 1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_DRAIN, 8'd0,   ROW_VALUE, 8'd254, 1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_DRAIN, 8'd0,   ROW_VALUE, 8'd128, 1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_DRAIN, 8'd0,   ROW_VALUE, 8'd64,  1'b1},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_DRAIN, 8'd0,   ROW_NONE,  8'd0,   1'b0},
    '{1'b1, REG_FRAME_HEIGHT, 12'd4, OP_PUSH, 8'd9,   ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd255, ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd3,   ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd3,   ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd0,   ROW_MODEL, 8'd0,   1'b0},
    '{1'b1, REG_FRAME_HEIGHT, 12'd3, OP_PUSH, 8'd250, ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd3,   ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd0,   ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_PUSH,  8'd255, ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_DRAIN, 8'd0,   ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_DRAIN, 8'd0,   ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_DRAIN, 8'd0,   ROW_MODEL, 8'd0,   1'b0},
    '{1'b0, REG_FRAME_WIDTH, 12'd0, OP_DRAIN, 8'd0,   ROW_MODEL, 8'd0,   1'b0}
  };

  median_filter_3x3_stream_unit #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_last(out_frame_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    return h;
  endfunction

  // Fifth smallest: fewer than five strictly below and at least five at or below.
  function automatic pix_t window_median();
    int   i, j, lt, le;
    pix_t pick;
    pick = win[4];
    for (i = 0; i < 9; i++) begin
      lt = 0;
      le = 0;
      for (j = 0; j < 9; j++) begin
        if (win[j] < win[i]) lt++;
        if (win[j] <= win[i]) le++;
      end
      if (lt <= 4 && le >= 5) pick = win[i];
    end
    return pick;
  endfunction

  function automatic void shift_column(pix_t px, int unsigned w);
    pix_t up, lo;
    int   k;
    up = '0;
    lo = '0;
    if (col_in < MAX_W) begin
      up = upper_line[col_in];
      lo = lower_line[col_in];
      upper_line[col_in] = lo;
      lower_line[col_in] = px;
    end
    for (k = 0; k < 6; k++) win[k] = win[k+3];
    win[6] = up;
    win[7] = lo;
    win[8] = px;
    if (col_in + 1 >= w) begin
      col_in = 0;
      row_in++;
    end else begin
      col_in++;
    end
  endfunction

  function automatic filt_res_t emit_pixel(int unsigned w, int unsigned h);
    int unsigned orow, ocol;
    filt_res_t   r;
    orow = out_cnt / w;
    ocol = out_cnt % w;
    if (orow == 0 || orow + 1 >= h || ocol == 0 || ocol + 1 >= w) r.px = win[4];
    else r.px = window_median();
    r.last = (out_cnt + 1 >= w * h);
    if (r.last) begin
      col_in = 0;
      row_in = 0;
      out_cnt = 0;
      frame_closed = 1'b1;
    end else begin
      out_cnt++;
    end
    return r;
  endfunction

  // Returns 1 when the item is taken into the frame; dropped items change nothing.
  function automatic bit predict_filter_step(op_t op, pix_t px, output bit has_res,
                                             output filt_res_t res);
    int unsigned w, h;
    bit          started;
    w = eff_width();
    h = eff_height();
    has_res = 1'b0;
    res = '0;
    if (op == OP_PUSH) begin
      if (row_in >= h) return 1'b0;
      started = (row_in >= 2) || (row_in == 1 && col_in >= 1);
      shift_column(px, w);
      if (started) begin
        res = emit_pixel(w, h);
        has_res = 1'b1;
      end
      return 1'b1;
    end
    if (row_in < h) return 1'b0;
    shift_column('0, w);
    res = emit_pixel(w, h);
    has_res = 1'b1;
    return 1'b1;
  endfunction

  function automatic pix_t rand_pixel();
    pix_t v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = pix_t'(120 + $urandom_range(3));  // near-equal values force ties
      default: v = pix_t'($urandom_range(255));
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Enter and leave right after a rising edge; valid stays high on return.
  task automatic offer(input op_t op, input pix_t px, input row_kind_e kind,
                       input filt_res_t typed, output bit taken);
    bit        has_res;
    filt_res_t res;
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_pixel_in <= px;
    do @(posedge clk); while (!in_ready);
    taken = predict_filter_step(op, px, has_res, res);
    if (kind == ROW_VALUE) expected_pixels.push_back(typed);
    else if (kind == ROW_MODEL && has_res) expected_pixels.push_back(res);
  endtask

  // Drop valid, wait out all pending pixels plus pipeline depth.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    @(posedge clk);
  endtask

  // One frame of well-formed items with about 5% dropped ones mixed in.
  task automatic run_frame(input int unsigned mid_at, input int unsigned squeeze_at,
                           output int unsigned n);
    bit  taken, noise, pushing;
    op_t op;
    n = 0;
    frame_closed = 1'b0;
    while (!frame_closed) begin
      noise   = ($urandom_range(99) < 5);
      pushing = (row_in < eff_height());
      op      = (pushing ^ noise) ? OP_PUSH : OP_DRAIN;
      offer(op, rand_pixel(), ROW_MODEL, '0, taken);
      if (taken) n++;
      if (taken && n == squeeze_at) squeeze_req = 1'b1;
      if (taken && n == mid_at && !frame_closed) begin
        // resize in the middle of the frame
        settle();
        if ($urandom_range(1)) write_reg(REG_FRAME_WIDTH, DIM_W'($urandom_range(3, 40)));
        else write_reg(REG_FRAME_HEIGHT, DIM_W'($urandom_range(3, 12)));
      end
    end
  endtask

  initial begin
    int unsigned counted, n, fw, fh;
    dir_row_t    row;
    filt_res_t   typed;
    bit          taken;
    foreach (win[k]) win[k] = '0;
    foreach (upper_line[k]) begin
      upper_line[k] = '0;
      lower_line[k] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(REG_FRAME_WIDTH, DIM_W'(MIN_DIM));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(MIN_DIM));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.cfg_en) begin
        settle();
        write_reg(row.cfg_reg, row.cfg_val);
      end
      typed.px   = row.exp_px;
      typed.last = row.exp_last;
      offer(row.op, row.px, row.kind, typed, taken);
    end

    // Widest line first so every line-store entry holds a known value; the
    // receiver holds off once results flow.
    settle();
    write_reg(REG_FRAME_WIDTH, DIM_W'(MAX_W));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(MIN_DIM));
    run_frame(0, 3000, n);

    settle();
    write_reg(REG_FRAME_WIDTH, DIM_W'(MIN_DIM));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(DIM_MAX));
    calm = 1'b1;
    run_frame(0, 0, n);
    calm = 1'b0;

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      settle();
      fw = ($urandom_range(3) == 0) ? $urandom_range(3, 64) : $urandom_range(3, 12);
      fh = $urandom_range(3, 10);
      write_reg(REG_FRAME_WIDTH, DIM_W'(fw));
      write_reg(REG_FRAME_HEIGHT, DIM_W'(fh));
      run_frame(($urandom_range(3) == 0) ? $urandom_range(1, fw * fh) : 0, 0, n);
      counted += n;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: random stalls, none while calm, one long hold-off on request.
  initial begin
    int hold;
    bit squeezed;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        for (hold = 0; hold < SQUEEZE_CYC; hold++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 22);
      end
    end
  end

  always @(posedge clk) begin
    filt_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %0d last %0b", out_pixel_out,
                                  out_frame_last));
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_out !== want.px)
          report_mismatch($sformatf("pixel %0d, want %0d", out_pixel_out, want.px));
        if (out_frame_last !== want.last)
          report_mismatch($sformatf("frame_last %0b, want %0b", out_frame_last, want.last));
      end
    end
  end

  // Stop when neither channel nor the register port moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
